// ===== hw/rtl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the transfer sequencer
// Item codes, result flags and the decoded item and result records.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int RetryWidth = 16;

    localparam logic [1:0] OP_BEGIN    = 2'd0;
    localparam logic [1:0] OP_TRANSFER = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] KIND_REQ  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_OK    = 2'd1;
    localparam logic [1:0] ACK_WAIT  = 2'd2;
    localparam logic [1:0] ACK_FAULT = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;

    localparam logic [4:0] FL_OK       = 5'h01;
    localparam logic [4:0] FL_WAIT     = 5'h02;
    localparam logic [4:0] FL_FAULT    = 5'h04;
    localparam logic [4:0] FL_ERROR    = 5'h08;
    localparam logic [4:0] FL_MISMATCH = 5'h10;

    localparam logic [7:0] RDBUFF_ADDR = 8'h0C;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    typedef struct packed {
        logic [1:0]            op;
        logic                  req_ap;
        logic                  req_read;
        logic                  req_match;
        logic                  req_set_mask;
        logic [7:0]            addr;
        logic [31:0]           word;
        logic [RetryWidth-1:0] wait_retries;
        logic [RetryWidth-1:0] match_retries;
        logic                  last_transfer;
        logic [1:0]            bus_ack;
        logic [1:0]            bus_error;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        bus_is_ap;
        logic        bus_read;
        logic [7:0]  bus_addr;
        logic [31:0] data_word;
        logic [7:0]  completed;
        logic [4:0]  status_flags;
        logic [1:0]  final_ack;
        logic        last;
    } result_t;

    function automatic logic [4:0] ack_flags(input logic [1:0] ack, input logic [1:0] err);
        logic [4:0] f;
        if (ack == ACK_WAIT) f = FL_WAIT;
        else if (ack == ACK_FAULT) f = FL_FAULT;
        else if (err != ERR_NONE) f = FL_ERROR;
        else f = FL_OK;
        return f;
    endfunction

endpackage

// ===== hw/rtl/dts_front.sv =====
// ----------------------------------------------------------------------------
// dts_front: input stage
// Accepts items, drops unused op codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module dts_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dts_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output dts_pkg::item_t  q_item
);
    dts_pkg::item_t mem [dts_pkg::QueueDepth];
    logic [dts_pkg::QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dts_pkg::QueuePtrW:0]   count_reg, count_next;
    logic push, pop, useful;

    assign useful   = (in_item.op != dts_pkg::OP_NONE);
    assign in_ready = (count_reg != (dts_pkg::QueuePtrW+1)'(dts_pkg::QueueDepth));
    assign push     = in_valid && in_ready && useful;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end
endmodule

// ===== hw/rtl/dts_engine.sv =====
// ----------------------------------------------------------------------------
// dts_engine: transfer engine
// Runs the sequence state machine on one queued item per cycle while its
// two-entry output buffer drains, and sends up to two results through it.
// ----------------------------------------------------------------------------
module dts_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  dts_pkg::item_t   q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output dts_pkg::result_t out_data
);
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_BUSY  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;
    localparam int RW = dts_pkg::RetryWidth;

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] mask_reg, mask_next;
    logic [RW-1:0] wait_limit_reg, wait_limit_next, match_limit_reg, match_limit_next;
    logic [RW-1:0] wait_left_reg, wait_left_next, match_left_reg, match_left_next;
    logic [7:0]  done_count_reg, done_count_next;
    dts_pkg::item_t cur_reg, cur_next;

    dts_pkg::result_t slot_reg [2];
    logic [1:0] cnt_reg;
    dts_pkg::result_t r0, r1, req_res, done_res;
    logic [1:0] nres;
    logic [1:0] ack;
    logic [4:0] fin_flags;
    logic [1:0] fin_ack;
    logic fin;
    logic pop, take;

    assign pop       = out_valid && out_ready;
    assign q_ready   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign take      = q_valid && q_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[0];
    assign ack       = (q_item.bus_ack == dts_pkg::ACK_NONE) ? dts_pkg::ACK_FAULT
                                                              : q_item.bus_ack;

    always_comb begin
        req_res           = '0;
        req_res.kind      = dts_pkg::KIND_REQ;
        req_res.bus_is_ap = cur_next.req_ap;
        req_res.bus_read  = cur_next.req_read;
        req_res.bus_addr  = cur_next.addr;
        req_res.data_word = cur_next.req_read ? 32'd0 : cur_next.word;
        req_res.last      = 1'b1;
    end

    always_comb begin
        phase_next       = phase_reg;
        mask_next        = mask_reg;
        wait_limit_next  = wait_limit_reg;
        match_limit_next = match_limit_reg;
        wait_left_next   = wait_left_reg;
        match_left_next  = match_left_reg;
        done_count_next  = done_count_reg;
        cur_next         = cur_reg;
        r0 = '0;
        r1 = '0;
        nres = 2'd0;
        fin = 1'b0;
        fin_flags = dts_pkg::FL_OK;
        fin_ack = dts_pkg::ACK_OK;
        unique case (q_item.op)
            dts_pkg::OP_BEGIN: begin
                mask_next        = q_item.word;
                wait_limit_next  = q_item.wait_retries;
                match_limit_next = q_item.match_retries;
                wait_left_next   = '0;
                match_left_next  = '0;
                done_count_next  = '0;
                phase_next       = PH_READY;
            end
            dts_pkg::OP_TRANSFER: begin
                if (phase_reg == PH_READY) begin
                    cur_next = q_item;
                    if (!q_item.req_read && q_item.req_set_mask) begin
                        mask_next = q_item.word;
                        done_count_next = done_count_reg + 8'd1;
                        fin = q_item.last_transfer;
                    end else begin
                        wait_left_next  = wait_limit_reg;
                        match_left_next = match_limit_reg;
                        phase_next = PH_BUSY;
                        r0 = req_res;
                        nres = 2'd1;
                    end
                end
            end
            dts_pkg::OP_COMPLETE: begin
                if (phase_reg == PH_CHECK) begin
                    fin = 1'b1;
                    fin_flags = dts_pkg::ack_flags(ack, q_item.bus_error);
                    fin_ack = ack;
                end else if (phase_reg == PH_BUSY) begin
                    if ((q_item.bus_ack == dts_pkg::ACK_WAIT
                         || q_item.bus_error == dts_pkg::ERR_TIMEOUT)
                        && wait_left_reg != '0) begin
                        wait_left_next = wait_left_reg - 1'b1;
                        r0 = req_res;
                        nres = 2'd1;
                    end else if (q_item.bus_error != dts_pkg::ERR_NONE
                                 || ack != dts_pkg::ACK_OK) begin
                        fin = 1'b1;
                        fin_flags = dts_pkg::ack_flags(ack, q_item.bus_error);
                        fin_ack = ack;
                    end else if (cur_reg.req_read) begin
                        if (cur_reg.req_match
                            && (q_item.word & mask_reg) != cur_reg.word) begin
                            if (match_left_reg == '0) begin
                                fin = 1'b1;
                                fin_flags = dts_pkg::FL_MISMATCH;
                            end else begin
                                match_left_next = match_left_reg - 1'b1;
                                wait_left_next = wait_limit_reg;
                                r0 = req_res;
                                nres = 2'd1;
                            end
                        end else begin
                            done_count_next = done_count_reg + 8'd1;
                            r0.kind = dts_pkg::KIND_READ;
                            r0.data_word = q_item.word;
                            r0.last = !cur_reg.last_transfer;
                            nres = 2'd1;
                            if (cur_reg.last_transfer) fin = 1'b1;
                            else phase_next = PH_READY;
                        end
                    end else begin
                        done_count_next = done_count_reg + 8'd1;
                        if (cur_reg.last_transfer) begin
                            phase_next = PH_CHECK;
                            r0.kind = dts_pkg::KIND_REQ;
                            r0.bus_read = 1'b1;
                            r0.bus_addr = dts_pkg::RDBUFF_ADDR;
                            r0.last = 1'b1;
                            nres = 2'd1;
                        end else begin
                            phase_next = PH_READY;
                        end
                    end
                end
            end
            default: ;
        endcase
        done_res = '0;
        done_res.kind = dts_pkg::KIND_DONE;
        done_res.completed = done_count_next;
        done_res.status_flags = fin_flags;
        done_res.final_ack = fin_ack;
        done_res.last = 1'b1;
        if (fin) begin
            phase_next = PH_IDLE;
            if (nres == 2'd0) r0 = done_res;
            else r1 = done_res;
            nres = nres + 2'd1;
        end
    end

    // two-slot buffer, head in slot 0; a take needs it empty or its only result leaving
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            if (take) cnt_reg <= nres;
            else if (pop) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            slot_reg[0] <= r0;
            slot_reg[1] <= r1;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            mask_reg        <= '0;
            wait_limit_reg  <= '0;
            match_limit_reg <= '0;
            wait_left_reg   <= '0;
            match_left_reg  <= '0;
            done_count_reg  <= '0;
            cur_reg         <= '0;
        end else if (take) begin
            phase_reg       <= phase_next;
            mask_reg        <= mask_next;
            wait_limit_reg  <= wait_limit_next;
            match_limit_reg <= match_limit_next;
            wait_left_reg   <= wait_left_next;
            match_left_reg  <= match_left_next;
            done_count_reg  <= done_count_next;
            cur_reg         <= cur_next;
        end
    end
endmodule

// ===== hw/rtl/dap_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// dap_transfer_sequencer: serial wire debug transfer sequencer
// Top level: input queue feeding the transfer engine.
// ----------------------------------------------------------------------------
// Items enter a four-entry queue and the engine decides one item per cycle
// when not stalled, giving up to two results through a two-slot output
// buffer; with the result side ready the block sustains one item per clock
// while each item gives at most one result. The engine stalls while its
// output buffer holds two results, or one that is not leaving. The op code
// travels on s_tuser and the result kind on m_tuser; op code 3 items are
// dropped at the input. Field layouts are beside the ports.
module dap_transfer_sequencer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_ap[0], req_read[1], req_match[2], req_set_mask[3], addr[11:4],
    // word[43:12], wait_retries[59:44], match_retries[75:60], bus_ack[77:76],
    // bus_error[79:78]
    input  logic [79:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bus_is_ap[0], bus_read[1], bus_addr[9:2], data_word[41:10],
    // completed[49:42], status_flags[54:50], final_ack[56:55], zero fill to 64
    output logic [63:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    dts_pkg::item_t   in_item, q_item;
    dts_pkg::result_t res;
    logic q_valid, q_ready;

    always_comb begin
        in_item.op            = s_tuser;
        in_item.req_ap        = s_tdata[0];
        in_item.req_read      = s_tdata[1];
        in_item.req_match     = s_tdata[2];
        in_item.req_set_mask  = s_tdata[3];
        in_item.addr          = s_tdata[11:4];
        in_item.word          = s_tdata[43:12];
        in_item.wait_retries  = s_tdata[44 +: dts_pkg::RetryWidth];
        in_item.match_retries = s_tdata[60 +: dts_pkg::RetryWidth];
        in_item.last_transfer = s_tlast;
        in_item.bus_ack       = s_tdata[77:76];
        in_item.bus_error     = s_tdata[79:78];
    end

    dts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    dts_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {7'd0, res.final_ack, res.status_flags, res.completed,
                      res.data_word, res.bus_addr, res.bus_read, res.bus_is_ap};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == dts_pkg::KIND_DONE) |-> m_tlast)
        else $error("done result without last");
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == dts_pkg::KIND_DONE) |-> $onehot(m_tdata[54:50]))
        else $error("done flags not one-hot");
    a_req_noflags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != dts_pkg::KIND_DONE) |-> (m_tdata[56:42] == '0))
        else $error("status fields set on non-done result");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the transfer sequencer
// Drives begin, transfer, completion and op 3 items with random gaps, predicts
// bus requests, read data and done records, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dts_pkg::*;

    localparam logic [1:0] ERR_OTHER = 2'd2;
    localparam int CycleLimit = 400000;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_READY, SEQ_BUSY, SEQ_CHECK} seq_phase_t;

    typedef struct {
        item_t it;
        bit    hold;   // wait until all results are in before offering
    } pend_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    dap_transfer_sequencer dut (.*);

    always #1 aclk = ~aclk;

    pend_t   pend_q[$];
    result_t exp_results[$];
    item_t   drv_item;
    int      errors = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      total_items = 0;
    int      seqs_done = 0;
    int      reads_out = 0;

    // predictor state
    logic [31:0]           p_mask;
    logic [RetryWidth-1:0] p_wait_lim, p_match_lim, p_wait_left, p_match_left;
    logic [7:0]            p_done_cnt;
    logic                  p_wr_check, p_aborted;
    item_t                 p_cur;
    seq_phase_t            p_phase;

    function automatic void push_result(logic [1:0] kind, logic ap, logic rd,
            logic [7:0] addr, logic [31:0] data, logic [7:0] cnt, logic [4:0] flags,
            logic [1:0] fack, logic lst);
        result_t r;
        r.kind = kind; r.bus_is_ap = ap; r.bus_read = rd; r.bus_addr = addr;
        r.data_word = data; r.completed = cnt; r.status_flags = flags;
        r.final_ack = fack; r.last = lst;
        exp_results.push_back(r);
    endfunction

    function automatic void reissue();
        push_result(KIND_REQ, p_cur.req_ap, p_cur.req_read, p_cur.addr,
                    p_cur.req_read ? 32'd0 : p_cur.word, 8'd0, 5'd0, 2'd0, 1'b1);
    endfunction

    function automatic void end_sequence(logic [4:0] flags, logic [1:0] ack);
        p_phase = SEQ_IDLE;
        p_aborted = (flags != FL_OK);
        seqs_done++;
        push_result(KIND_DONE, 1'b0, 1'b0, 8'd0, 32'd0, p_done_cnt, flags, ack, 1'b1);
    endfunction

    function automatic logic [4:0] flags_of(logic [1:0] ack, logic [1:0] err);
        if (ack == ACK_WAIT) return FL_WAIT;
        if (ack == ACK_FAULT) return FL_FAULT;
        if (err != ERR_NONE) return FL_ERROR;
        return FL_OK;
    endfunction

    function automatic void predict_sequencer(item_t it);
        logic [1:0] ack;
        case (it.op)
            OP_BEGIN: begin
                p_mask = it.word;
                p_wait_lim = it.wait_retries;
                p_match_lim = it.match_retries;
                p_wait_left = '0; p_match_left = '0; p_done_cnt = '0;
                p_wr_check = 1'b0; p_aborted = 1'b0;
                p_phase = SEQ_READY;
            end
            OP_TRANSFER: begin
                if (p_phase == SEQ_READY) begin
                    p_cur = it;
                    if (!it.req_read && it.req_set_mask) begin
                        p_mask = it.word;
                        p_wr_check = 1'b0;
                        p_done_cnt++;
                        if (it.last_transfer) end_sequence(FL_OK, ACK_OK);
                    end else begin
                        p_wait_left = p_wait_lim;
                        p_match_left = p_match_lim;
                        p_phase = SEQ_BUSY;
                        reissue();
                    end
                end
            end
            OP_COMPLETE: begin
                ack = (it.bus_ack == ACK_NONE) ? ACK_FAULT : it.bus_ack;
                if (p_phase == SEQ_CHECK) begin
                    end_sequence(flags_of(ack, it.bus_error), ack);
                end else if (p_phase == SEQ_BUSY) begin
                    if ((it.bus_ack == ACK_WAIT || it.bus_error == ERR_TIMEOUT)
                            && p_wait_left != 0) begin
                        p_wait_left--;
                        reissue();
                    end else if (it.bus_error != ERR_NONE || ack != ACK_OK) begin
                        end_sequence(flags_of(ack, it.bus_error), ack);
                    end else if (p_cur.req_read) begin
                        p_wr_check = 1'b0;
                        if (p_cur.req_match && (it.word & p_mask) != p_cur.word) begin
                            if (p_match_left == 0) begin
                                end_sequence(FL_MISMATCH, ACK_OK);
                            end else begin
                                p_match_left--;
                                p_wait_left = p_wait_lim;
                                reissue();
                            end
                        end else begin
                            p_done_cnt++;
                            reads_out++;
                            push_result(KIND_READ, 1'b0, 1'b0, 8'd0, it.word, 8'd0, 5'd0,
                                        2'd0, !p_cur.last_transfer);
                            if (p_cur.last_transfer) end_sequence(FL_OK, ACK_OK);
                            else p_phase = SEQ_READY;
                        end
                    end else begin
                        p_done_cnt++;
                        p_wr_check = 1'b1;
                        if (p_cur.last_transfer) begin
                            // final write: read buffer check
                            p_phase = SEQ_CHECK;
                            push_result(KIND_REQ, 1'b0, 1'b1, RDBUFF_ADDR, 32'd0, 8'd0,
                                        5'd0, 2'd0, 1'b1);
                        end else begin
                            p_phase = SEQ_READY;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------- stimulus construction
    function automatic item_t mk(logic [1:0] op);
        item_t it;
        it = '0;
        it.op = op;
        return it;
    endfunction

    task automatic add(item_t it, bit hold = 0);
        pend_t p;
        p.it = it;
        p.hold = hold;
        pend_q.push_back(p);
    endtask

    task automatic add_begin(logic [31:0] mask, logic [15:0] wl, logic [15:0] ml);
        item_t it;
        it = mk(OP_BEGIN);
        it.word = mask; it.wait_retries = wl; it.match_retries = ml;
        it.addr = 8'($urandom); it.req_ap = 1'($urandom); it.bus_ack = 2'($urandom);
        add(it);
    endtask

    task automatic add_xfer(logic ap, logic rd, logic mt, logic sm, logic [7:0] addr,
                            logic [31:0] w, logic lst);
        item_t it;
        it = mk(OP_TRANSFER);
        it.req_ap = ap; it.req_read = rd; it.req_match = mt; it.req_set_mask = sm;
        it.addr = addr; it.word = w; it.last_transfer = lst;
        add(it);
    endtask

    task automatic add_done(logic [1:0] ack, logic [1:0] err, logic [31:0] w);
        item_t it;
        it = mk(OP_COMPLETE);
        it.bus_ack = ack; it.bus_error = err; it.word = w;
        add(it);
    endtask

    function automatic logic [1:0] rand_ack();
        int r;
        r = $urandom_range(99);
        if (r < 72) return ACK_OK;
        if (r < 86) return ACK_WAIT;
        if (r < 93) return ACK_FAULT;
        return ACK_NONE;
    endfunction

    function automatic logic [1:0] rand_err();
        int r;
        r = $urandom_range(99);
        if (r < 86) return ERR_NONE;
        if (r < 95) return ERR_TIMEOUT;
        return 2'($urandom_range(3, 2));
    endfunction

    task automatic build_directed();
        item_t it;
        add_xfer(1, 1, 0, 0, 8'h10, 32'h1, 1);          // transfer with no sequence open
        add_done(ACK_OK, ERR_NONE, 32'h5);               // completion while idle
        it = mk(OP_NONE); it.word = '1; add(it);         // op 3 is dropped
        add_begin(32'hFFFF_FFFF, 16'd1, 16'd1);
        add_xfer(1, 0, 0, 0, 8'hFF, 32'hFFFF_FFFF, 0);
        add_done(ACK_OK, ERR_NONE, 32'h0);
        add_xfer(0, 1, 1, 0, 8'h00, 32'h0000_0012, 0);   // matched read
        add_done(ACK_OK, ERR_NONE, 32'h0);               // mismatch, retried
        add_done(ACK_OK, ERR_NONE, 32'h0000_0012);
        add_xfer(0, 0, 0, 1, 8'h04, 32'h0000_FFFF, 0);   // mask write
        add_xfer(1, 1, 0, 0, 8'h08, 32'h0, 0);
        add_done(ACK_WAIT, ERR_NONE, 32'h0);             // wait, re-issued
        add_done(ACK_OK, ERR_TIMEOUT, 32'h0);            // timeout with no retries left
        add_begin(32'h0, 16'd0, 16'd0);
        add_xfer(0, 0, 0, 0, 8'h04, 32'h8000_0001, 1);
        add_done(ACK_OK, ERR_NONE, 32'h0);               // read buffer check follows
        add_done(ACK_WAIT, ERR_NONE, 32'h0);             // check not retried
        add_begin(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_xfer(1, 1, 0, 0, 8'h0C, 32'h0, 1);
        add_done(ACK_NONE, ERR_NONE, 32'h0);             // missing ack is a fault
        add_begin(32'hFFFF_FFFF, 16'd0, 16'd0);
        add_xfer(0, 1, 1, 0, 8'h20, 32'hABCD_0000, 1);
        add_done(ACK_OK, ERR_NONE, 32'h1234_5678);       // mismatch ends it
        add_begin(32'h0, 16'd0, 16'd0);
        add_xfer(0, 0, 0, 1, 8'h00, 32'hF0F0_F0F0, 1);   // mask write as last
        add_begin(32'h0, 16'd2, 16'd0);
        add_xfer(1, 0, 0, 0, 8'h30, 32'h55, 0);
        add_begin(32'hFFFF_FFFF, 16'd0, 16'd0);          // restart mid sequence
        add_xfer(1, 1, 0, 0, 8'h40, 32'h0, 1);
        add_done(ACK_OK, ERR_OTHER, 32'h0);              // failure with ok ack
        add_begin(32'hFFFF_FFFF, 16'd0, 16'd0);
        add_xfer(1, 1, 0, 0, 8'h44, 32'h0, 1);
        add_done(ACK_OK, ERR_NONE, 32'hDEAD_BEEF);       // read with two results
    endtask

    task automatic build_random(int target);
        logic [31:0] gmask, val;
        logic [95:0] rbits;
        int nx, nc;
        logic rd, sm, mt, lst;
        item_t it;
        while (pend_q.size() < target) begin
            if ($urandom_range(19) == 0) begin
                rbits = {$urandom, $urandom, $urandom};
                it = item_t'(rbits[$bits(item_t)-1:0]);
                it.op = 2'($urandom_range(3));
                add(it, $urandom_range(9) == 0);
                continue;
            end
            case ($urandom_range(3))
                0: gmask = '1;
                1: gmask = 32'h0;
                default: gmask = $urandom;
            endcase
            add_begin(gmask, ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(3)),
                      ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(3)));
            if ($urandom_range(6) == 0) pend_q[$].hold = 1;
            nx = $urandom_range(6, 1);
            for (int i = 0; i < nx; i++) begin
                lst = (i == nx - 1) || ($urandom_range(15) == 0);
                rd = 1'($urandom);
                sm = (!rd && $urandom_range(4) == 0);
                mt = 1'($urandom);
                val = $urandom;
                if (rd && mt && $urandom_range(1)) val = val & gmask;
                if (sm) gmask = val;
                add_xfer(1'($urandom), rd, mt, sm, 8'($urandom), val, lst);
                if (!sm) begin
                    nc = $urandom_range(3, 1) + (!rd && lst);
                    for (int j = 0; j < nc; j++) begin
                        add_done(rand_ack(), rand_err(),
                                 (rd && mt && $urandom_range(2) != 0)
                                     ? (val | ($urandom & ~gmask)) : $urandom);
                    end
                end
                if (lst) break;
            end
        end
    endtask

    // ---------------- driver
    int drv_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_sequencer(drv_item);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0 &&
                             !(pend_q[0].hold && exp_results.size() > 0)) begin
                    drv_item = pend_q[0].it;
                    pend_q.pop_front();
                    s_tdata <= {drv_item.bus_error, drv_item.bus_ack,
                                drv_item.match_retries, drv_item.wait_retries,
                                drv_item.word, drv_item.addr, drv_item.req_set_mask,
                                drv_item.req_match, drv_item.req_read, drv_item.req_ap};
                    s_tuser <= drv_item.op;
                    s_tlast <= drv_item.last_transfer;
                    s_tvalid <= 1'b1;
                    if (pend_q.size() > 80 && $urandom_range(5) == 0)
                        drv_gap = $urandom_range(4, 1);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver hold-off
    int rx_hold = 0;
    bit hold_done = 0;

    // one long hold-off so the input queue fills and stalls
    always @(posedge aclk) begin
        if (!hold_done && results_seen >= 120) begin
            hold_done = 1;
            rx_hold = 80;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end
    end

    // ---------------- monitor
    int rx_gap = 0;

    always @(posedge aclk) begin
        result_t act, exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act.kind = m_tuser;
                act.bus_is_ap = m_tdata[0];
                act.bus_read = m_tdata[1];
                act.bus_addr = m_tdata[9:2];
                act.data_word = m_tdata[41:10];
                act.completed = m_tdata[49:42];
                act.status_flags = m_tdata[54:50];
                act.final_ack = m_tdata[56:55];
                act.last = m_tlast;
                results_seen++;
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, act);
                    errors++;
                end else begin
                    exp_r = exp_results.pop_front();
                    if (exp_r !== act) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, exp_r, act);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (pend_q.size() > 80 && $urandom_range(4) == 0)
                    rx_gap = $urandom_range(4, 1);
            end
        end
    end

    // ---------------- timeout
    int cycles = 0;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        p_mask = '0; p_wait_lim = '0; p_match_lim = '0; p_wait_left = '0;
        p_match_left = '0; p_done_cnt = '0; p_wr_check = 1'b0; p_aborted = 1'b0;
        p_cur = '0; p_phase = SEQ_IDLE;
        build_directed();
        build_random(750);
        total_items = pend_q.size();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (items_sent == total_items && exp_results.size() == 0);
        repeat (40) @(posedge aclk);
        $display("sent %0d items, checked %0d results (%0d read data, %0d sequence ends)",
                 items_sent, results_seen, reads_out, seqs_done);
        $display("covered retries, match retries, read buffer checks, aborts and stalls");
        if (errors == 0 && exp_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
